// ===== rtl/ebss_pkg.sv =====
// Shared types, character codes and helpers for the blank section scanner.
`timescale 1ns / 1ps
package ebss_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned RsnW  = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw   = $clog2(QDepth);

  localparam logic [CpW-1:0] ChCaret  = CpW'(8'h5E);
  localparam logic [CpW-1:0] ChOpen   = CpW'(8'h5B);
  localparam logic [CpW-1:0] ChClose  = CpW'(8'h5D);
  localparam logic [CpW-1:0] ChBslash = CpW'(8'h5C);
  localparam logic [CpW-1:0] ChNul    = '0;

  localparam logic [RsnW-1:0] StopCaret  = 3'd0;
  localparam logic [RsnW-1:0] StopNul    = 3'd1;
  localparam logic [RsnW-1:0] StopEoi    = 3'd2;
  localparam logic [RsnW-1:0] StopWblank = 3'd3;
  localparam logic [RsnW-1:0] StopBslash = 3'd4;

  localparam logic KindChar = 1'b0;
  localparam logic KindStop = 1'b1;

  typedef enum logic [7:0] {
    PH_TOP       = 8'b0000_0001,
    PH_TOP_ESC   = 8'b0000_0010,
    PH_OPEN1     = 8'b0000_0100,
    PH_BLOCK     = 8'b0000_1000,
    PH_BLOCK_ESC = 8'b0001_0000,
    PH_WB        = 8'b0010_0000,
    PH_WB_ESC    = 8'b0100_0000,
    PH_WB_CLOSE1 = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic            kind;
    logic [CpW-1:0]  chr;
    logic [RsnW-1:0] reason;
  } res_t;

  // One queued word: one or two results caused by a single input.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  function automatic res_t mk_char(logic [CpW-1:0] c);
    res_t r;
    r.kind   = KindChar;
    r.chr    = c;
    r.reason = '0;
    return r;
  endfunction

  function automatic res_t mk_stop(logic [RsnW-1:0] rsn);
    res_t r;
    r.kind   = KindStop;
    r.chr    = '0;
    r.reason = rsn;
    return r;
  endfunction

endpackage

// ===== rtl/ebss_front.sv =====
// Front end: accepts input words, runs the scan phase machine, builds result entries.
`timescale 1ns / 1ps
module ebss_front
  import ebss_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [CpW-1:0] code_point_i,
  input  logic           end_of_input_i,
  input  logic           q_full_i,
  output logic           push_o,
  output entry_t         push_data_o
);

  phase_e phase_q, phase_d;
  logic   mode_q;
  logic   shadow_q, shadow_d;
  logic   accept;
  logic   any;
  entry_t ent;

  logic [CpW-1:0] c;
  logic           eoi;

  assign c          = code_point_i;
  assign eoi        = end_of_input_i;
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    phase_d  = phase_q;
    shadow_d = shadow_q;
    any      = 1'b0;
    ent      = '0;
    case (phase_q)
      PH_TOP: begin
        shadow_d = mode_q;
        if (eoi) begin
          any = 1'b1; ent.r0 = mk_stop(StopEoi);
        end else if (c == ChCaret) begin
          any = 1'b1; ent.r0 = mk_stop(StopCaret);
        end else if (c == ChNul) begin
          any = 1'b1; ent.r0 = mk_stop(StopNul);
        end else if (c == ChOpen) begin
          phase_d = PH_OPEN1;
        end else begin
          any = 1'b1; ent.r0 = mk_char(c);
          phase_d = (c == ChBslash) ? PH_TOP_ESC : PH_TOP;
        end
      end
      PH_TOP_ESC: begin
        any = 1'b1;
        phase_d = PH_TOP;
        if (eoi || c == ChNul) ent.r0 = mk_stop(StopBslash);
        else                   ent.r0 = mk_char(c);
      end
      PH_OPEN1: begin
        any = 1'b1;
        phase_d = PH_TOP;
        if (eoi) begin
          ent.two = 1'b1; ent.r0 = mk_char(ChOpen); ent.r1 = mk_stop(StopEoi);
        end else if (c == ChOpen) begin
          if (shadow_q) begin
            ent.two = 1'b1; ent.r0 = mk_char(ChOpen); ent.r1 = mk_char(ChOpen);
            phase_d = PH_WB;
          end else begin
            ent.r0 = mk_stop(StopWblank);
          end
        end else begin
          ent.r0 = mk_char(ChOpen);
          if (c != ChNul) begin
            ent.two = 1'b1; ent.r1 = mk_char(c);
            if (c == ChBslash)     phase_d = PH_BLOCK_ESC;
            else if (c != ChClose) phase_d = PH_BLOCK;
          end
        end
      end
      PH_BLOCK: begin
        phase_d = PH_TOP;
        if (eoi) begin
          any = 1'b1; ent.r0 = mk_stop(StopEoi);
        end else if (c != ChNul) begin
          any = 1'b1; ent.r0 = mk_char(c);
          if (c == ChBslash)     phase_d = PH_BLOCK_ESC;
          else if (c != ChClose) phase_d = PH_BLOCK;
        end
      end
      PH_BLOCK_ESC: begin
        any = 1'b1;
        if (eoi) begin
          ent.r0 = mk_stop(StopBslash); phase_d = PH_TOP;
        end else begin
          ent.r0 = mk_char(c); phase_d = PH_BLOCK;
        end
      end
      PH_WB, PH_WB_CLOSE1: begin
        phase_d = PH_TOP;
        if (eoi) begin
          any = 1'b1; ent.r0 = mk_stop(StopEoi);
        end else if (c != ChNul) begin
          any = 1'b1; ent.r0 = mk_char(c);
          if (c == ChBslash)                       phase_d = PH_WB_ESC;
          else if (c != ChClose)                   phase_d = PH_WB;
          else if (phase_q == PH_WB)               phase_d = PH_WB_CLOSE1;
        end
      end
      PH_WB_ESC: begin
        any = 1'b1;
        if (eoi) begin
          ent.r0 = mk_stop(StopBslash); phase_d = PH_TOP;
        end else begin
          ent.r0 = mk_char(c); phase_d = PH_WB;
        end
      end
      default: begin
        phase_d = PH_TOP;
      end
    endcase
  end

  assign push_o      = accept && any;
  assign push_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TOP;
      shadow_q <= 1'b0;
      mode_q   <= 1'b0;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        shadow_q <= shadow_d;
      end
      if (cfg_we_i) mode_q <= cfg_wdata_i;
    end
  end

endmodule

// ===== rtl/ebss_queue.sv =====
// Short entry queue between the front end and the result sequencer.
`timescale 1ns / 1ps
module ebss_queue
  import ebss_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  output logic   empty_o,
  input  logic   pop_i,
  output entry_t head_o
);

  entry_t             mem_q [QDepth];
  logic [QAw-1:0]     wptr_q, rptr_q;
  logic [QAw:0]       cnt_q;

  assign full_o  = (cnt_q == (QAw+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + QAw'(1);
      if (pop_i)  rptr_q <= rptr_q + QAw'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + (QAw+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (QAw+1)'(1);
    end
  end

endmodule

// ===== rtl/ebss_back.sv =====
// Back end: unpacks queued entries into single result words in an output register.
`timescale 1ns / 1ps
module ebss_back
  import ebss_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  entry_t          head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            kind_o,
  output logic [CpW-1:0]  char_out_o,
  output logic [RsnW-1:0] stop_reason_o,
  output logic            last_o
);

  logic valid_q;
  logic sel_q;
  logic load;
  logic fin;
  res_t res_q;
  logic last_q;
  res_t pick;

  assign load = !q_empty_i && (!valid_q || !out_stall_i);
  assign fin  = sel_q || !head_i.two;
  assign pop_o = load && fin;
  assign pick  = sel_q ? head_i.r1 : head_i.r0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        sel_q   <= !fin;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= pick;
      last_q <= fin;
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = res_q.kind;
  assign char_out_o    = res_q.chr;
  assign stop_reason_o = res_q.reason;
  assign last_o        = last_q;

endmodule

// ===== rtl/escaped_blank_section_scanner_unit.sv =====
// Path: a result word is written into the entry queue and then into the output register before it is valid.
// Throughput: one input per cycle; the output side issues one result per cycle while out_stall_i
//   is low, so an input that yields two results holds the result sequencer until both are issued. The four-entry
//   queue absorbs short runs of these; the input stalls only while the queue is full.
// Reset: rst_ni clears the phase machine, mode register, queue and output valid at once.
// Top level of the blank section scanner.
`timescale 1ns / 1ps
module escaped_blank_section_scanner_unit
  import ebss_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [CpW-1:0]  code_point_i,
  input  logic            end_of_input_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            kind_o,
  output logic [CpW-1:0]  char_out_o,
  output logic [RsnW-1:0] stop_reason_o,
  output logic            last_o
);

  logic   push, pop, full, empty;
  entry_t push_data, head;

  ebss_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .code_point_i   (code_point_i),
    .end_of_input_i (end_of_input_i),
    .q_full_i       (full),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  ebss_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .empty_o     (empty),
    .pop_i       (pop),
    .head_o      (head)
  );

  ebss_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .char_out_o    (char_out_o),
    .stop_reason_o (stop_reason_o),
    .last_o        (last_o)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the blank section scanner: directed and random streams checked by a scoreboard.
module tb_top;
  import ebss_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandWords = 950;
  localparam int unsigned NumRandPhases = 6;

  typedef struct packed {
    logic            kind;
    logic [CpW-1:0]  chr;
    logic [RsnW-1:0] reason;
    logic            last;
  } emit_t;

  class blank_scan_board;
    logic   wb_mode;
    logic   wb_latched;
    phase_e scan_ph;
    emit_t  pending_emits[$];
    emit_t  step_emits[$];
    int     mismatches;

    function new();
      wb_mode    = 1'b0;
      wb_latched = 1'b0;
      scan_ph    = PH_TOP;
      mismatches = 0;
    endfunction

    function void set_mode(logic v);
      wb_mode = v;
    endfunction

    function void emit_char(logic [CpW-1:0] c);
      step_emits.push_back(emit_t'{KindChar, c, '0, 1'b0});
    endfunction

    function void emit_stop(logic [RsnW-1:0] r);
      step_emits.push_back(emit_t'{KindStop, '0, r, 1'b0});
      scan_ph = PH_TOP;
    endfunction

    // character inside a bracket block or a word blank
    function void region_char(logic [CpW-1:0] c, logic wb, logic after_close);
      if (c == ChNul) begin
        scan_ph = PH_TOP;
      end else begin
        emit_char(c);
        if (c == ChBslash) begin
          scan_ph = wb ? PH_WB_ESC : PH_BLOCK_ESC;
        end else if (c == ChClose) begin
          if (!wb || after_close) scan_ph = PH_TOP;
          else scan_ph = PH_WB_CLOSE1;
        end else begin
          scan_ph = wb ? PH_WB : PH_BLOCK;
        end
      end
    endfunction

    // accepted input word: work out the results it causes
    function void absorb_code(logic [CpW-1:0] cp, logic eoi);
      step_emits.delete();
      case (scan_ph)
        PH_TOP: begin
          wb_latched = wb_mode;
          if (eoi) emit_stop(StopEoi);
          else if (cp == ChCaret) emit_stop(StopCaret);
          else if (cp == ChNul) emit_stop(StopNul);
          else if (cp == ChOpen) scan_ph = PH_OPEN1;
          else begin
            emit_char(cp);
            scan_ph = (cp == ChBslash) ? PH_TOP_ESC : PH_TOP;
          end
        end
        PH_TOP_ESC: begin
          if (eoi || cp == ChNul) emit_stop(StopBslash);
          else begin
            emit_char(cp);
            scan_ph = PH_TOP;
          end
        end
        PH_OPEN1: begin
          if (eoi) begin
            emit_char(ChOpen);
            emit_stop(StopEoi);
          end else if (cp == ChOpen) begin
            if (wb_latched) begin
              emit_char(ChOpen);
              emit_char(ChOpen);
              scan_ph = PH_WB;
            end else begin
              emit_stop(StopWblank);
            end
          end else begin
            emit_char(ChOpen);
            region_char(cp, 1'b0, 1'b0);
          end
        end
        PH_BLOCK: begin
          if (eoi) emit_stop(StopEoi);
          else region_char(cp, 1'b0, 1'b0);
        end
        PH_BLOCK_ESC: begin
          if (eoi) emit_stop(StopBslash);
          else begin
            emit_char(cp);
            scan_ph = PH_BLOCK;
          end
        end
        PH_WB: begin
          if (eoi) emit_stop(StopEoi);
          else region_char(cp, 1'b1, 1'b0);
        end
        PH_WB_ESC: begin
          if (eoi) emit_stop(StopBslash);
          else begin
            emit_char(cp);
            scan_ph = PH_WB;
          end
        end
        default: begin
          if (eoi) emit_stop(StopEoi);
          else region_char(cp, 1'b1, 1'b1);
        end
      endcase
      if (step_emits.size() > 0) step_emits[step_emits.size()-1].last = 1'b1;
      foreach (step_emits[i]) pending_emits.push_back(step_emits[i]);
    endfunction

    function void report(string what, emit_t want, emit_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected kind=%0d char=%h reason=%0d last=%0d, got kind=%0d char=%h reason=%0d last=%0d",
                 what, want.kind, want.chr, want.reason, want.last,
                 got.kind, got.chr, got.reason, got.last);
    endfunction

    function void check_emit(logic kind, logic [CpW-1:0] chr, logic [RsnW-1:0] reason,
                             logic last);
      emit_t got;
      emit_t want;
      got = emit_t'{kind, chr, reason, last};
      if (pending_emits.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = pending_emits.pop_front();
      if (got !== want) report("result mismatch", want, got);
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic            cfg_wdata_i = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [CpW-1:0]  code_point_i = '0;
  logic            end_of_input_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic            kind_o;
  logic [CpW-1:0]  char_out_o;
  logic [RsnW-1:0] stop_reason_o;
  logic            last_o;

  blank_scan_board scan_board = new();
  logic [CpW:0]    plan[$];
  int              burst_left = 0;
  int              words_sent = 0;
  int              idle_cycles = 0;
  int              stall_style = 0;
  int              stall_left = 0;
  int              cyc = 0;

  escaped_blank_section_scanner_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .code_point_i   (code_point_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .char_out_o     (char_out_o),
    .stop_reason_o  (stop_reason_o),
    .last_o         (last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // receiver stall pattern: free, random light, periodic, random heavy
  always @(posedge clk_i) begin
    cyc++;
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(20, 120);
    end
    stall_left--;
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      2: out_stall_i <= ((cyc % 5) < 2);
      default: out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) scan_board.set_mode(cfg_wdata_i);
      if (in_valid_i && !in_stall_o) scan_board.absorb_code(code_point_i, end_of_input_i);
      if (out_valid_o && !out_stall_i)
        scan_board.check_emit(kind_o, char_out_o, stop_reason_o, last_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  function automatic logic [CpW-1:0] rand_code();
    case ($urandom_range(0, 11))
      0: return CpW'($urandom);
      1: return CpW'($urandom_range(0, 21'h10FFFF));
      2: return ChCaret;
      3: return ChNul;
      4: return ChOpen;
      5: return ChClose;
      6: return ChBslash;
      default: return CpW'($urandom_range(32, 126));
    endcase
  endfunction

  function automatic logic [CpW-1:0] body_code();
    if ($urandom_range(0, 5) == 0) return rand_code();
    return CpW'($urandom_range(32, 90));
  endfunction

  function void put(logic [CpW-1:0] c);
    plan.push_back({1'b0, c});
  endfunction

  function void put_end();
    plan.push_back({1'b1, CpW'($urandom)});
  endfunction

  function void put_body(int n);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        put(ChBslash);
        put(rand_code());
      end else if ($urandom_range(0, 29) == 0) begin
        put(ChNul);
      end else begin
        put(body_code());
      end
    end
  endfunction

  // one random piece of a blank section, mostly well formed
  function void append_segment();
    case ($urandom_range(0, 17))
      0, 1, 2: repeat ($urandom_range(1, 6)) put(rand_code());
      3: begin
        put(ChBslash);
        if ($urandom_range(0, 7) == 0) put_end();
        else put(rand_code());
      end
      4, 5, 6: begin
        put(ChOpen);
        put_body($urandom_range(0, 6));
        if ($urandom_range(0, 9) == 0) put_end();
        else put(ChClose);
      end
      7, 8, 9, 10: begin
        put(ChOpen);
        put(ChOpen);
        put_body($urandom_range(0, 6));
        if ($urandom_range(0, 3) == 0) begin
          put(ChClose);
          put_body($urandom_range(1, 3));
        end
        if ($urandom_range(0, 9) == 0) begin
          put_end();
        end else begin
          put(ChClose);
          put(ChClose);
        end
      end
      11: put(ChCaret);
      12: put(ChNul);
      13, 14: put_end();
      15: begin
        put(ChOpen);
        put_end();
      end
      default: put(rand_code());
    endcase
  endfunction

  task automatic send_word(logic [CpW-1:0] cp, logic eoi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 40);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    code_point_i   <= cp;
    end_of_input_i <= eoi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_plan();
    foreach (plan[i]) begin
      send_word(plan[i][CpW-1:0], plan[i][CpW]);
      words_sent++;
    end
    plan.delete();
  endtask

  // mode change only once the block has drained
  task automatic write_mode(logic v);
    in_valid_i <= 1'b0;
    while (scan_board.pending_emits.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mode(1'b0);
    put(21'h10FFFF);
    put(21'h1FFFFF);
    put(ChCaret);
    put(ChNul);
    put(ChBslash); put(ChCaret);
    put(ChBslash); put(ChNul);
    put(ChOpen); put(CpW'("x")); put(ChClose);
    put(ChOpen); put(ChOpen);
    put(ChOpen); put_end();
    put(ChOpen); put(ChNul);
    put_end();
    put(ChOpen); put(ChBslash); put(ChNul); put(ChBslash); put_end();
    send_plan();

    write_mode(1'b1);
    put(ChOpen); put(ChOpen); put(ChClose); put(ChClose);
    send_plan();

    words_sent = 0;
    for (int ph = 0; ph < NumRandPhases; ph++) begin
      if (ph < 2) write_mode(ph[0]);
      else write_mode(1'($urandom));
      while (words_sent < (ph + 1) * RandWords / NumRandPhases) begin
        append_segment();
        send_plan();
      end
    end

    in_valid_i <= 1'b0;
    while (scan_board.pending_emits.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (scan_board.mismatches == 0 && scan_board.pending_emits.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== escaped_blank_section_scanner_unit.f =====
rtl/ebss_pkg.sv
rtl/ebss_front.sv
rtl/ebss_queue.sv
rtl/ebss_back.sv
rtl/escaped_blank_section_scanner_unit.sv
dv/tb_top.sv
